>>> rtl/sobel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants for the sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // default line buffer depth
  localparam int MaxLineWidthDefault = 1024;

  // register widths
  localparam int WidthBits  = 11;
  localparam int HeightBits = 16;
  localparam int ThrBits    = 11;
  localparam int PixBits    = 8;
  localparam int MagBits    = 11;

  // register reset values
  localparam logic [WidthBits-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightBits-1:0] HeightReset = 16'd480;
  localparam logic [ThrBits-1:0]    ThrReset    = 11'd0;

  // register indexes (word address)
  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegThreshold   = 2'd2;

  // square root datapath
  localparam int SumBits = 21;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic advance;
    logic square;
    logic root_step;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic interior;
    logic root_done;
    logic out_blocked;
  } sts_t;

endpackage

>>> rtl/sobel_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_ctrl
// Sequencer: takes one item through read and gradient; an interior one goes on to square and root.
// ----------------------------------------------------------------------------
module sobel_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sobel_pkg::sts_t   sts_i,
  output sobel_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SGrad = 3'd2;
  localparam logic [2:0] SSqr  = 3'd3;
  localparam logic [2:0] SRoot = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  logic [2:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SRead;
        end
      end
      SRead: begin
        cmd_o.mem_read = 1'b1;
        state_d        = SGrad;
      end
      SGrad: begin
        cmd_o.advance = 1'b1;
        state_d       = sts_i.interior ? SSqr : SIdle;
      end
      SSqr: begin
        cmd_o.square = 1'b1;
        state_d      = SRoot;
      end
      SRoot: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (!sts_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

>>> rtl/sobel_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_datapath
// Line buffers, 3x3 window, gradients, bit-serial square root, output register.
// ----------------------------------------------------------------------------
module sobel_datapath #(
  parameter int MaxLineWidth = sobel_pkg::MaxLineWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sobel_pkg::cmd_t                    cmd_i,
  output sobel_pkg::sts_t                    sts_o,
  input  logic [sobel_pkg::PixBits-1:0]      pixel_value_i,
  input  logic [sobel_pkg::WidthBits-1:0]    frame_width_i,
  input  logic [sobel_pkg::HeightBits-1:0]   frame_height_i,
  input  logic [sobel_pkg::ThrBits-1:0]      edge_threshold_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sobel_pkg::MagBits-1:0]      edge_magnitude_o,
  output logic                               row_end_o,
  output logic                               frame_end_o
);

  localparam int CW = (MaxLineWidth > 2) ? $clog2(MaxLineWidth) : 1;
  localparam int WW = (CW + 1 > sobel_pkg::WidthBits) ? CW + 1 : sobel_pkg::WidthBits;
  localparam int PB = sobel_pkg::PixBits;
  localparam int HB = sobel_pkg::HeightBits;
  localparam int SB = sobel_pkg::SumBits;
  localparam logic [WW-1:0] MaxW = WW'(MaxLineWidth);

  logic [PB-1:0] mem_upper [MaxLineWidth];
  logic [PB-1:0] mem_middle [MaxLineWidth];

  logic [PB-1:0] pix_q;
  logic [PB-1:0] top_q, mid_q;
  logic [PB-1:0] win_q [6];
  logic [CW-1:0] col_q;
  logic [HB-1:0] row_q;
  logic [9:0]    ax_q, ay_q;
  logic          row_end_q, frame_end_q;
  logic [SB-1:0] rem_q, root_q, bit_q;
  logic          out_valid_q;
  logic [sobel_pkg::MagBits-1:0] mag_out_q;
  logic          row_out_q, frame_out_q;

  // effective frame size
  logic [WW-1:0] w_ext, w_eff;
  logic [HB-1:0] h_eff;
  logic          last_col, last_row, interior;
  always_comb begin
    w_ext = WW'(frame_width_i);
    if (w_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_ext > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = w_ext;
    end
    h_eff    = (frame_height_i < HB'(3)) ? HB'(3) : frame_height_i;
    last_col = WW'(col_q) >= (w_eff - WW'(1));
    last_row = row_q >= (h_eff - HB'(1));
    interior = (WW'(col_q) >= WW'(2)) && (row_q >= HB'(2));
  end

  // pixel capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q <= pixel_value_i;
    end
  end

  // line buffers: read in the read step, written in the gradient step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      top_q <= mem_upper[col_q];
      mid_q <= mem_middle[col_q];
    end
    if (cmd_i.advance) begin
      mem_upper[col_q]  <= mid_q;
      mem_middle[col_q] <= pix_q;
    end
  end

  // gradients
  logic [9:0]  sum_r, sum_l, sum_b, sum_t;
  logic signed [10:0] gx, gy;
  always_comb begin
    sum_r = 10'(top_q) + {1'b0, mid_q, 1'b0} + 10'(pix_q);
    sum_l = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
    sum_b = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(pix_q);
    sum_t = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(top_q);
    gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
  end

  // window, counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.advance) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_q;
      win_q[4] <= mid_q;
      win_q[5] <= pix_q;
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + HB'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // absolute gradients and flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      ax_q        <= gx[10] ? 10'(-gx) : gx[9:0];
      ay_q        <= gy[10] ? 10'(-gy) : gy[9:0];
      row_end_q   <= last_col;
      frame_end_q <= last_col && last_row;
    end
  end

  // square sum, then one root bit per cycle
  logic [SB:0]   trial;
  logic [19:0]   sq_x, sq_y;
  always_comb begin
    sq_x  = 20'(ax_q) * 20'(ax_q);
    sq_y  = 20'(ay_q) * 20'(ay_q);
    trial = {1'b0, root_q} + {1'b0, bit_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      rem_q  <= SB'(sq_x) + SB'(sq_y);
      root_q <= '0;
      bit_q  <= SB'(1) << (SB - 1);
    end else if (cmd_i.root_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q  <= rem_q - trial[SB-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // rounding
  logic [sobel_pkg::MagBits-1:0] mag;
  always_comb begin
    mag = sobel_pkg::MagBits'(root_q) + sobel_pkg::MagBits'(rem_q > root_q);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mag_out_q   <= (mag > edge_threshold_i) ? mag : '0;
      row_out_q   <= row_end_q;
      frame_out_q <= frame_end_q;
    end
  end

  assign sts_o.interior    = interior;
  assign sts_o.root_done   = bit_q[0];
  assign sts_o.out_blocked = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign edge_magnitude_o = mag_out_q;
  assign row_end_o        = row_out_q;
  assign frame_end_o      = frame_out_q;

endmodule

>>> rtl/sobel_edge_magnitude_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_threshold
// Streaming 3x3 sobel gradient magnitude with threshold and row/frame flags.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per item; each interior pixel yields one
// item holding round(sqrt(gx^2+gy^2)), or zero when at or below the threshold,
// and border pixels yield nothing. One item is in work at a time: a border
// pixel steps through accept, line buffer read and window update, an interior
// pixel on through square and the bit-serial square root that resolves one of
// its 11 result bits per cycle. A finished result waits in the output register
// while the next item is taken. Line buffers need no clearing after reset.
module sobel_edge_magnitude_threshold #(
  parameter int MaxLineWidth = sobel_pkg::MaxLineWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sobel_pkg::PixBits-1:0]    pixel_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sobel_pkg::MagBits-1:0]    edge_magnitude_o,
  output logic                             row_end_o,
  output logic                             frame_end_o
);

  logic [sobel_pkg::WidthBits-1:0]  frame_width_q;
  logic [sobel_pkg::HeightBits-1:0] frame_height_q;
  logic [sobel_pkg::ThrBits-1:0]    edge_threshold_q;
  sobel_pkg::cmd_t cmd;
  sobel_pkg::sts_t sts;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= sobel_pkg::WidthReset;
      frame_height_q   <= sobel_pkg::HeightReset;
      edge_threshold_q <= sobel_pkg::ThrReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        sobel_pkg::RegFrameWidth:  frame_width_q    <= pwdata[sobel_pkg::WidthBits-1:0];
        sobel_pkg::RegFrameHeight: frame_height_q   <= pwdata[sobel_pkg::HeightBits-1:0];
        sobel_pkg::RegThreshold:   edge_threshold_q <= pwdata[sobel_pkg::ThrBits-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      sobel_pkg::RegFrameWidth:  prdata = 32'(frame_width_q);
      sobel_pkg::RegFrameHeight: prdata = 32'(frame_height_q);
      sobel_pkg::RegThreshold:   prdata = 32'(edge_threshold_q);
      default:                   prdata = '0;
    endcase
  end

  sobel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sobel_datapath #(
    .MaxLineWidth (MaxLineWidth)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pixel_value_i    (pixel_value_i),
    .frame_width_i    (frame_width_q),
    .frame_height_i   (frame_height_q),
    .edge_threshold_i (edge_threshold_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .edge_magnitude_o (edge_magnitude_o),
    .row_end_o        (row_end_o),
    .frame_end_o      (frame_end_o)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sobel edge magnitude block.
// ----------------------------------------------------------------------------
// Frames of grayscale pixels go in over the input channel. A scoreboard keeps
// its own line stores, window and counters, and predicts the magnitude and the
// row and frame flags of every interior pixel. Each output item is compared
// with the oldest prediction. Registers are set over the APB port while the
// block is idle. The frame sizes cover clamped widths and heights, a height
// change in the middle of a frame, and random small frames with random
// thresholds. Both sides idle at random, and the receiver holds off once for
// a long stretch while the sender keeps offering pixels.
// ----------------------------------------------------------------------------
module tb;

  localparam int LineDepth  = 1024;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [sobel_pkg::MagBits-1:0] mag;
    logic                          row_end;
    logic                          frame_end;
  } edge_item_t;

  // predicts edge items and checks the block against them
  class edge_scoreboard;
    logic [sobel_pkg::PixBits-1:0] upper [LineDepth];
    logic [sobel_pkg::PixBits-1:0] middle [LineDepth];
    logic [sobel_pkg::PixBits-1:0] win [6];
    int unsigned col, row;
    int unsigned width, height, thr;
    edge_item_t expected_edges [$];
    int unsigned n_pixels, n_edges, n_errors;

    function new();
      foreach (upper[i]) upper[i] = '0;
      foreach (middle[i]) middle[i] = '0;
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      width = sobel_pkg::WidthReset;
      height = sobel_pkg::HeightReset;
      thr = sobel_pkg::ThrReset;
      n_pixels = 0;
      n_edges = 0;
      n_errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        sobel_pkg::RegFrameWidth: width = val[sobel_pkg::WidthBits-1:0];
        sobel_pkg::RegFrameHeight: height = val[sobel_pkg::HeightBits-1:0];
        sobel_pkg::RegThreshold: thr = val[sobel_pkg::ThrBits-1:0];
        default: ;
      endcase
    endfunction

    // rounded root of gx^2+gy^2
    function int unsigned round_mag(int gx, int gy);
      int unsigned s, k;
      s = gx * gx + gy * gy;
      k = 0;
      while ((k + 1) * (k + 1) <= s) k++;
      if (s > k * k + k) k++;
      return k;
    endfunction

    function void note_pixel(logic [sobel_pkg::PixBits-1:0] pix);
      int unsigned w, h, c, m;
      logic [sobel_pkg::PixBits-1:0] top, mid;
      logic last_col, last_row;
      int gx, gy;
      edge_item_t e;
      w = (width < 3) ? 3 : ((width > LineDepth) ? LineDepth : width);
      h = (height < 3) ? 3 : height;
      c = col % LineDepth;
      top = upper[c];
      mid = middle[c];
      last_col = (c >= w - 1);
      last_row = (row >= h - 1);
      n_pixels++;
      if (c >= 2 && row >= 2) begin
        gx = (int'(top) + 2 * int'(mid) + int'(pix))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        gy = (int'(win[2]) + 2 * int'(win[5]) + int'(pix))
           - (int'(win[0]) + 2 * int'(win[3]) + int'(top));
        m = round_mag(gx, gy);
        e.mag = (m > thr) ? m[sobel_pkg::MagBits-1:0] : '0;
        e.row_end = last_col;
        e.frame_end = last_col && last_row;
        expected_edges.push_back(e);
      end
      // shift window and line stores
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = pix;
      upper[c] = mid;
      middle[c] = pix;
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : ((row + 1) & 16'hffff);
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_item(logic [sobel_pkg::MagBits-1:0] mag, logic re, logic fe);
      edge_item_t e;
      n_edges++;
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected item mag %0d row_end %0b frame_end %0b",
                 $time, mag, re, fe);
        n_errors++;
        return;
      end
      e = expected_edges.pop_front();
      if (e.mag !== mag) begin
        $display("%0t: edge_magnitude expected %0d actual %0d", $time, e.mag, mag);
        n_errors++;
      end
      if (e.row_end !== re) begin
        $display("%0t: row_end expected %0b actual %0b", $time, e.row_end, re);
        n_errors++;
      end
      if (e.frame_end !== fe) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, e.frame_end, fe);
        n_errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel, penable, pwrite;
  logic [3:0]                    paddr;
  logic [31:0]                   pwdata, prdata;
  logic                          pready;
  logic                          in_valid, in_ready;
  logic [sobel_pkg::PixBits-1:0] pixel;
  logic                          out_valid, out_ready;
  logic [sobel_pkg::MagBits-1:0] edge_mag;
  logic                          row_end, frame_end;

  edge_scoreboard sb;
  logic hold_done;

  sobel_edge_magnitude_threshold dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .pixel_value_i   (pixel),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .edge_magnitude_o(edge_mag),
    .row_end_o       (row_end),
    .frame_end_o     (frame_end)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // quiet window with no idling on either side
  function automatic logic quiet_window();
    return sb.n_pixels >= 200 && sb.n_pixels < 300;
  endfunction

  // register write, setup then access
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h, logic [31:0] t);
    reg_write(sobel_pkg::RegFrameWidth, w);
    reg_write(sobel_pkg::RegFrameHeight, h);
    reg_write(sobel_pkg::RegThreshold, t);
  endtask

  // stop offering, let every expected item arrive, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_edges.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [sobel_pkg::PixBits-1:0] p);
    if (!quiet_window() && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk_i); while (!in_ready);
    sb.note_pixel(p);
  endtask

  // rows of pixels; style 0 random, 1 vertical edge, 2 and 3 corners
  task automatic send_rows(int unsigned w, int unsigned rows, int style);
    logic [sobel_pkg::PixBits-1:0] p;
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        case (style)
          1: p = (c == w - 1) ? 8'hff : 8'h00;
          2: p = (r == rows - 1 || c == w - 1) ? 8'hff : 8'h00;
          3: p = (r == 0 || c == 0) ? 8'hff : 8'h00;
          default: p = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                                : 8'($urandom);
        endcase
        send_pixel(p);
      end
    end
  endtask

  // receiver: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (!hold_done && sb.n_pixels >= 30) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
    end else begin
      out_ready <= quiet_window() ? 1'b1 : ($urandom_range(99) >= 24);
    end
  end

  // output check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_item(edge_mag, row_end, frame_end);
  end

  // watchdog on cycles with no accepted item
  int unsigned idle_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("sobel_edge_magnitude_threshold regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned w, h;
    sb = new();
    hold_done = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    pixel = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clamped sizes, edges and corners
    set_frame(32'd0, 32'd1, 32'd0);
    send_rows(3, 3, 1);
    send_rows(3, 3, 2);
    send_rows(3, 3, 3);
    drain();

    // height changed mid frame ends it at the current row
    set_frame(32'd6, 32'd65535, 32'd100);
    send_rows(6, 5, 0);
    drain();
    reg_write(sobel_pkg::RegFrameHeight, 32'd3);
    send_rows(6, 1, 0);
    drain();

    // random small frames
    while (sb.n_pixels < 400) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      set_frame(w, h, $urandom_range(3) == 0 ? 32'd0 : $urandom_range(0, 1500));
      send_rows(w, h, 0);
      drain();
    end

    $display("%0d pixels sent, %0d edge items checked, %0d mismatches",
             sb.n_pixels, sb.n_edges, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_edges.size() == 0) begin
      $display("sobel_edge_magnitude_threshold regression: pass");
    end else begin
      $display("%0d expected items never arrived", sb.expected_edges.size());
      $display("sobel_edge_magnitude_threshold regression: fail");
    end
    $finish;
  end

endmodule
